// File: hdl/tnqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone note queue player package
// Shared widths, command codes and the classified command type passed from
// the front end to the note player.
// ----------------------------------------------------------------------------
package tnqp_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 32;
  localparam int CMDQ_DEPTH          = 2;

  localparam int CMD_W       = 2;
  localparam int FREQ_W      = 16;
  localparam int DUR_W       = 16;
  localparam int COUNT_OUT_W = 6;
  localparam int NOTE_W      = FREQ_W + DUR_W;
  localparam int TIME_W      = DUR_W + 5;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [DUR_W-1:0] ELAPSED_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PUSH,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } cmd_t;

endpackage

// File: hdl/tnqp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone note queue player front end
// Accepts items, decodes the command code and holds them in a short queue
// until the note player takes them.
// ----------------------------------------------------------------------------
module tnqp_front
  import tnqp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [FREQ_W-1:0] note_freq,
  input  logic [DUR_W-1:0]  note_duration,
  output logic              q_valid,
  output cmd_t              q_cmd,
  input  logic              q_pop
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slots [CMDQ_DEPTH];
  cmd_t             decoded;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;

  always_comb begin
    decoded.freq = note_freq;
    decoded.dur  = note_duration;
    case (command)
      CMD_TICK:  decoded.op = OP_TICK;
      CMD_PUSH:  decoded.op = OP_PUSH;
      CMD_CLEAR: decoded.op = OP_CLEAR;
      default:   decoded.op = OP_NOP;
    endcase
  end

  assign cmd_ready = (fill != CNT_W'(CMDQ_DEPTH));
  assign push      = cmd_valid && cmd_ready;
  assign q_valid   = (fill != '0);
  assign q_cmd     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

endmodule

// File: hdl/tnqp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone note queue player back end
// Holds the note memory and the playing note, carries out one command at a
// time and registers the result for the output channel.
// ----------------------------------------------------------------------------
module tnqp_back
  import tnqp_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [FREQ_W-1:0]      tone_freq,
  output logic                   note_active,
  output logic [COUNT_OUT_W-1:0] queue_count,
  output logic                   push_dropped
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [NOTE_W-1:0]   mem [QUEUE_DEPTH];
  logic [NOTE_W-1:0]   rd_data;
  logic [IDX_W-1:0]    head, head_next, head_inc, tail;
  logic [IDX_W:0]      tail_sum;
  logic [CNT_W-1:0]    total, total_next;
  logic                active, active_next;
  logic [DUR_W-1:0]    elapsed, elapsed_next, e_inc;
  logic [FREQ_W-1:0]   driven, driven_next;
  logic [DUR_W-1:0]    cur_dur, cur_dur_next;
  logic [TIME_W-1:0]   nine_dur, nine_dur_next, ten_e;
  logic                dropped_next;
  logic                res_load;
  logic                mem_we;
  logic                slot_free;
  logic [CNT_W+COUNT_OUT_W-1:0] total_ext;

  assign slot_free = !res_valid || res_ready;
  assign e_inc     = (elapsed != ELAPSED_MAX) ? elapsed + DUR_W'(1) : elapsed;
  assign ten_e     = TIME_W'({e_inc, 3'b000}) + TIME_W'({e_inc, 1'b0}) + TIME_W'(10);
  assign head_inc  = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign tail_sum  = (IDX_W+1)'(head) + (IDX_W+1)'(total);
  assign tail      = (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH)) ?
                     IDX_W'(tail_sum - (IDX_W+1)'(QUEUE_DEPTH)) : tail_sum[IDX_W-1:0];
  assign total_ext = {{COUNT_OUT_W{1'b0}}, total_next};

  always_comb begin
    state_next    = state;
    head_next     = head;
    total_next    = total;
    active_next   = active;
    elapsed_next  = elapsed;
    driven_next   = driven;
    cur_dur_next  = cur_dur;
    nine_dur_next = nine_dur;
    dropped_next  = 1'b0;
    res_load      = 1'b0;
    mem_we        = 1'b0;
    q_pop         = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_TICK: begin
              if (!active) begin
                if (total != '0) begin
                  state_next = S_LOAD;
                end else begin
                  res_load = 1'b1;
                end
              end else begin
                res_load     = 1'b1;
                elapsed_next = e_inc;
                if (ten_e > nine_dur) begin
                  driven_next = '0;
                end
                if (e_inc >= cur_dur) begin
                  head_next   = head_inc;
                  active_next = 1'b0;
                  if (total != '0) begin
                    total_next = total - CNT_W'(1);
                  end
                end
              end
            end
            OP_PUSH: begin
              res_load = 1'b1;
              if (total >= CNT_W'(QUEUE_DEPTH)) begin
                dropped_next = 1'b1;
              end else begin
                mem_we     = 1'b1;
                total_next = total + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              res_load     = 1'b1;
              head_next    = '0;
              total_next   = '0;
              active_next  = 1'b0;
              elapsed_next = '0;
              driven_next  = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_LOAD: begin
        res_load      = 1'b1;
        state_next    = S_IDLE;
        active_next   = 1'b1;
        elapsed_next  = '0;
        driven_next   = rd_data[FREQ_W-1:0];
        cur_dur_next  = rd_data[NOTE_W-1:FREQ_W];
        nine_dur_next = TIME_W'({rd_data[NOTE_W-1:FREQ_W], 3'b000}) +
                        TIME_W'(rd_data[NOTE_W-1:FREQ_W]);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      total     <= '0;
      active    <= 1'b0;
      elapsed   <= '0;
      driven    <= '0;
      cur_dur   <= '0;
      nine_dur  <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      total    <= total_next;
      active   <= active_next;
      elapsed  <= elapsed_next;
      driven   <= driven_next;
      cur_dur  <= cur_dur_next;
      nine_dur <= nine_dur_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      tone_freq    <= driven_next;
      note_active  <= active_next;
      queue_count  <= total_ext[COUNT_OUT_W-1:0];
      push_dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= {q_cmd.dur, q_cmd.freq};
    end
    rd_data <= mem[head];
  end

endmodule

// File: hdl/tone_note_queue_player_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone note queue player
// Buzzer note sequencer fed from a queue of notes.
//
// Input channel (cmd_valid/cmd_ready): command 0 is a one-millisecond tick,
// 1 pushes note_freq/note_duration into the note queue, 2 clears the queue
// and silences the tone, 3 does nothing. Every item gives exactly one result
// on the output channel (res_valid/res_ready): the tone frequency now driven,
// whether a note is being timed, the queue count and a dropped-push flag.
// Results are registered after the command queue; a tick that starts a new
// note also waits on the note memory read of the head entry. The player takes
// one item per cycle while the result slot is free and no note is loading.
// A two-entry command queue keeps accepting while a result waits; when the
// receiver stalls the result is held and, once the command queue is full,
// cmd_ready drops. Reset empties both queues, stops the note and silences
// the tone; the note memory itself is not cleared.
// ----------------------------------------------------------------------------
module tone_note_queue_player_top
  import tnqp_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic [CMD_W-1:0]       command,
  input  logic [FREQ_W-1:0]      note_freq,
  input  logic [DUR_W-1:0]       note_duration,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [FREQ_W-1:0]      tone_freq,
  output logic                   note_active,
  output logic [COUNT_OUT_W-1:0] queue_count,
  output logic                   push_dropped
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  tnqp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .command       (command),
    .note_freq     (note_freq),
    .note_duration (note_duration),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  tnqp_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .tone_freq    (tone_freq),
    .note_active  (note_active),
    .queue_count  (queue_count),
    .push_dropped (push_dropped)
  );

endmodule

// File: hdl/tnqp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone note queue player checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tnqp_checker
  import tnqp_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
  input logic                   clk,
  input logic                   rst,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [FREQ_W-1:0]      tone_freq,
  input logic                   note_active,
  input logic [COUNT_OUT_W-1:0] queue_count,
  input logic                   push_dropped
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(tone_freq) && $stable(queue_count))
    else $error("stalled result changed");

  a_tone_needs_note: assert property (@(posedge clk) disable iff (rst)
    res_valid && (tone_freq != '0) |-> note_active)
    else $error("tone driven with no note playing");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && push_dropped |-> queue_count == COUNT_OUT_W'(QUEUE_DEPTH))
    else $error("push dropped while queue not full");

endmodule

bind tone_note_queue_player_top tnqp_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .tone_freq    (tone_freq),
  .note_active  (note_active),
  .queue_count  (queue_count),
  .push_dropped (push_dropped)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone note queue player testbench
// Drives ticks, note pushes, clears and the unused command code through the
// command channel, predicts every result from a behavioral copy of the note
// queue and player, and checks each result field by field. Both channels
// idle in random bursts. One long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb;
  import tnqp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int NOTE_SLOTS  = DEFAULT_QUEUE_DEPTH;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_ITEMS  = 120;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } note_cmd_t;

  typedef struct {
    logic [FREQ_W-1:0]      tone;
    logic                   active;
    logic [COUNT_OUT_W-1:0] count;
    logic                   dropped;
  } player_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_ready;
  logic [CMD_W-1:0]       command = '0;
  logic [FREQ_W-1:0]      note_freq = '0;
  logic [DUR_W-1:0]       note_duration = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  logic [FREQ_W-1:0]      tone_freq;
  logic                   note_active;
  logic [COUNT_OUT_W-1:0] queue_count;
  logic                   push_dropped;

  tone_note_queue_player_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .command      (command),
    .note_freq    (note_freq),
    .note_duration(note_duration),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .tone_freq    (tone_freq),
    .note_active  (note_active),
    .queue_count  (queue_count),
    .push_dropped (push_dropped)
  );

  always #5 clk = ~clk;

  note_cmd_t   send_q[$];
  player_out_t expected_outs[$];

  // player model state
  logic [NOTE_W-1:0] note_mem [NOTE_SLOTS];
  int unsigned       head_slot = 0;
  int unsigned       notes_queued = 0;
  logic              playing = 1'b0;
  int unsigned       elapsed = 0;
  logic [FREQ_W-1:0] driven_tone = '0;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_started = 0;
  int n_refused = 0;
  int n_clears = 0;
  logic cmd_taken = 1'b0;

  task automatic flag_error(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic advance_player(input note_cmd_t it);
    player_out_t o;
    int unsigned dur;
    int unsigned slot;
    o.dropped = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        if (!playing) begin
          if (notes_queued != 0) begin
            elapsed = 0;
            driven_tone = note_mem[head_slot][FREQ_W-1:0];
            playing = 1'b1;
            n_started++;
          end
        end else begin
          dur = 32'(note_mem[head_slot][NOTE_W-1:FREQ_W]);
          if (elapsed < 32'(ELAPSED_MAX)) elapsed++;
          if (elapsed >= (dur * 9) / 10) driven_tone = '0;
          if (elapsed >= dur) begin
            head_slot = (head_slot + 1) % NOTE_SLOTS;
            if (notes_queued != 0) notes_queued--;
            playing = 1'b0;
          end
        end
      end
      CMD_PUSH: begin
        if (notes_queued >= NOTE_SLOTS) begin
          o.dropped = 1'b1;
          n_refused++;
        end else begin
          slot = (head_slot + notes_queued) % NOTE_SLOTS;
          note_mem[slot] = {it.dur, it.freq};
          notes_queued++;
        end
      end
      CMD_CLEAR: begin
        head_slot = 0;
        notes_queued = 0;
        playing = 1'b0;
        elapsed = 0;
        driven_tone = '0;
        n_clears++;
      end
      default: ;
    endcase
    o.tone   = driven_tone;
    o.active = playing;
    o.count  = notes_queued[COUNT_OUT_W-1:0];
    expected_outs.insert(expected_outs.size(), o);
  endtask

  function automatic void add_item(input logic [CMD_W-1:0] c, input logic [FREQ_W-1:0] f,
                                   input logic [DUR_W-1:0] d);
    note_cmd_t it;
    it.cmd  = c;
    it.freq = f;
    it.dur  = d;
    send_q.insert(send_q.size(), it);
  endfunction

  function automatic void add_ticks(input int n);
    for (int i = 0; i < n; i++) add_item(CMD_TICK, FREQ_W'($urandom), DUR_W'($urandom));
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    logic [FREQ_W-1:0] f;
    f = FREQ_W'($urandom);
    if ($urandom_range(0, 7) == 0) f = '0;
    return f;
  endfunction

  // driver: advance to the next item once the current one is taken
  int          send_gap = 0;
  int unsigned send_odds = 2;
  int unsigned send_cyc = 0;

  always @(negedge clk) begin : driver
    note_cmd_t it;
    send_cyc <= send_cyc + 1;
    if (send_cyc[6:0] == 0) send_odds <= $urandom_range(0, 3);
    if (!rst && (!cmd_valid || cmd_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        cmd_valid <= 1'b0;
      end else if (send_q.size() >= CALM_ITEMS && send_odds != 0 &&
                   $urandom_range(0, 7) < send_odds) begin
        send_gap <= $urandom_range(0, 14);
        cmd_valid <= 1'b0;
      end else if (send_q.size() != 0) begin
        it = send_q.pop_front();
        cmd_valid     <= 1'b1;
        command       <= it.cmd;
        note_freq     <= it.freq;
        note_duration <= it.dur;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the block
  int          sink_gap = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned sink_odds = 2;
  int unsigned sink_cyc = 0;

  always @(negedge clk) begin : receiver
    sink_cyc <= sink_cyc + 1;
    if (sink_cyc[6:0] == 64) sink_odds <= $urandom_range(0, 3);
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (!hold_done && n_in >= 400) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      res_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      res_ready <= 1'b0;
    end else if (send_q.size() >= CALM_ITEMS && sink_odds != 0 &&
                 $urandom_range(0, 7) < sink_odds) begin
      sink_gap <= $urandom_range(0, 14);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin : monitor
    note_cmd_t   it;
    player_out_t want;
    cmd_taken <= !rst && cmd_valid && cmd_ready;
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        it.cmd  = command;
        it.freq = note_freq;
        it.dur  = note_duration;
        n_in++;
        advance_player(it);
      end
      if (res_valid && res_ready) begin
        n_out++;
        if (expected_outs.size() == 0) begin
          flag_error($sformatf("result %0d with nothing expected", n_out));
        end else begin
          want = expected_outs.pop_front();
          if (tone_freq !== want.tone)
            flag_error($sformatf("result %0d tone_freq %0d, expected %0d",
                                 n_out, tone_freq, want.tone));
          if (note_active !== want.active)
            flag_error($sformatf("result %0d note_active %0b, expected %0b",
                                 n_out, note_active, want.active));
          if (queue_count !== want.count)
            flag_error($sformatf("result %0d queue_count %0d, expected %0d",
                                 n_out, queue_count, want.count));
          if (push_dropped !== want.dropped)
            flag_error($sformatf("result %0d push_dropped %0b, expected %0b",
                                 n_out, push_dropped, want.dropped));
        end
      end
    end
  end

  int stall_cycles = 0;

  always @(posedge clk) begin : watchdog
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n;
    // directed: empty tick, unused code, zero duration, rest, nine tenths cutoff
    add_item(CMD_TICK, '0, '0);
    add_item(CMD_NOP, '1, '1);
    add_item(CMD_PUSH, '1, '0);
    add_item(CMD_PUSH, '0, 16'd2);
    add_item(CMD_PUSH, 16'd1234, 16'd10);
    add_item(CMD_TICK, '1, '1);
    add_item(CMD_TICK, '0, '0);
    add_item(CMD_TICK, '0, '0);
    add_item(CMD_PUSH, '1, '1);
    add_ticks(2);
    add_item(CMD_TICK, '0, '0);
    add_ticks(10);
    add_item(CMD_TICK, '0, '0);
    add_ticks(2);
    add_item(CMD_CLEAR, '1, '1);
    add_item(CMD_TICK, '0, '0);

    while (send_q.size() < 900) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            add_item(CMD_PUSH, pick_freq(), DUR_W'($urandom_range(0, 12)));
          add_ticks($urandom_range(n * 3, n * 10));
        end
        4: add_ticks($urandom_range(1, 20));
        5: begin
          n = $urandom_range(30, 36);
          for (int i = 0; i < n; i++)
            add_item(CMD_PUSH, pick_freq(), DUR_W'($urandom_range(0, 3)));
          add_ticks($urandom_range(0, 30));
        end
        6: add_item(CMD_CLEAR, FREQ_W'($urandom), DUR_W'($urandom));
        7: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            add_item(CMD_W'($urandom_range(0, 3)), FREQ_W'($urandom), DUR_W'($urandom));
        end
        8: begin
          add_item(CMD_PUSH, pick_freq(), DUR_W'($urandom_range(20, 80)));
          add_ticks($urandom_range(10, 90));
        end
        default: begin
          add_item(CMD_CLEAR, FREQ_W'($urandom), DUR_W'($urandom));
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++)
            add_item(CMD_PUSH, pick_freq(), DUR_W'($urandom_range(0, 8)));
          add_ticks($urandom_range(n * 2, n * 9));
        end
      endcase
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (send_q.size() != 0 || cmd_valid) @(negedge clk);
    while (expected_outs.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (expected_outs.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_outs.size()));

    $display("checked %0d results from %0d items: %0d notes started, %0d clears,",
             n_out, n_in, n_started, n_clears);
    $display("%0d pushes refused at a full queue, one %0d-cycle receiver hold-off",
             n_refused, HOLD_CYCLES);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
